/* hdl/scl_pkg.sv */
package scl_pkg;

  localparam int CHANNELS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int DELAY_BITS      = 16;
  localparam int DATA_BITS       = 32;
  localparam int REG_COUNT       = 4;
  localparam int ADDR_BITS       = $clog2(REG_COUNT * 4);
  localparam int REG_IDX_BITS    = $clog2(REG_COUNT);

  // Item kinds
  localparam logic [1:0] KIND_SAMPLE   = 2'd0;
  localparam logic [1:0] KIND_ARM      = 2'd1;
  localparam logic [1:0] KIND_TRK_RST  = 2'd2;
  localparam logic [1:0] KIND_HELD_CLR = 2'd3;

  // Register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_TMIN    = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_TMAX    = REG_IDX_BITS'(1);
  localparam logic [REG_IDX_BITS-1:0] REG_TIED    = REG_IDX_BITS'(2);
  localparam logic [REG_IDX_BITS-1:0] REG_LATCHED = REG_IDX_BITS'(3);

  typedef struct packed {
    logic tied;
    logic latched;
  } scl_mode_t;

  typedef struct packed {
    logic track;
    logic trk_clr;
    logic held_clr;
    logic calc;
    logic offs;
    logic fire;
  } scl_lane_ctl_t;

endpackage

/* hdl/scl_if.sv */
interface scl_in_if #(
  parameter int CHANNELS    = scl_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = scl_pkg::SAMPLE_BITS_DEF
);
  import scl_pkg::*;

  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             kind;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]   sample;
  logic [DELAY_BITS-1:0]                  latch_delay;

  modport source (output valid, kind, sample, latch_delay, input ready);
  modport sink   (input valid, kind, sample, latch_delay, output ready);
endinterface

interface scl_out_if #(
  parameter int CHANNELS    = scl_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = scl_pkg::SAMPLE_BITS_DEF
);
  logic                                   valid;
  logic                                   ready;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]   scaled;
  logic                                   range_armed;

  modport source (output valid, scaled, range_armed, input ready);
  modport sink   (input valid, scaled, range_armed, output ready);
endinterface

/* hdl/multichannel_autorange_scaler_unit.sv */
// Channel   Direction  Handshake        Beat contents
// in_ch     in         valid/ready      kind, sample per channel, latch_delay
// out_ch    out        valid/ready      scaled sample per channel, range_armed
// cfg (APB) in         psel/penable     target_min, target_max, tied_shift, held_select
//
// A sample item passes through these steps: tracking and countdown on accept, shift search,
// offset and group-shift merge, then scaling into the output register.
// A control item skips to the output step. in_ch.ready is high only between items.
// The output register lets the next item enter while a result waits; a stalled
// out_ch holds the block in its last step. Reset (rst_n low, synchronous) clears
// tracking, held values, countdown, state, output valid and configuration registers.
module multichannel_autorange_scaler_unit #(
  parameter int CHANNELS    = scl_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = scl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  scl_in_if.sink                        in_ch,
  scl_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scl_pkg::ADDR_BITS-1:0] paddr,
  input  logic [scl_pkg::DATA_BITS-1:0] pwdata,
  output logic [scl_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import scl_pkg::*;

  localparam int SHW = $clog2(SAMPLE_BITS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CALC  = 2'd1;
  localparam logic [1:0] ST_OFFS  = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic                  cd_on_r, cd_on_nxt;
  logic [DELAY_BITS-1:0] cd_left_r, cd_left_nxt;
  logic                  fire_r, fire_nxt;
  logic                  armed_r;
  logic                  ctl_item_r;
  logic                  out_valid_r;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] scaled_r;
  logic                  range_r;

  logic                  acc;
  logic                  out_free;
  logic                  emit;
  scl_mode_t             mode;
  scl_lane_ctl_t         lane_ctl;
  logic signed [SAMPLE_BITS-1:0] mid_want;
  logic signed [SAMPLE_BITS-1:0] half_want;
  logic [SHW-1:0]        group;
  logic [SHW-1:0]        sel_sh_nxt [CHANNELS];
  logic [SAMPLE_BITS-1:0] lane_out  [CHANNELS];

  scl_cfg #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mode_o      (mode),
    .mid_want_o  (mid_want),
    .half_want_o (half_want)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign emit        = (state_r == ST_FINAL) && out_free;

  assign lane_ctl.track    = acc && (in_ch.kind == KIND_SAMPLE);
  assign lane_ctl.trk_clr  = acc && (in_ch.kind == KIND_TRK_RST);
  assign lane_ctl.held_clr = acc && (in_ch.kind == KIND_HELD_CLR);
  assign lane_ctl.calc     = (state_r == ST_CALC);
  assign lane_ctl.offs     = (state_r == ST_OFFS);
  assign lane_ctl.fire     = fire_r;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    scl_lane #(.SAMPLE_BITS(SAMPLE_BITS), .SHW(SHW)) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl_i        (lane_ctl),
      .mode_i       (mode),
      .smp_i        ($signed(in_ch.sample[c])),
      .mid_want_i   (mid_want),
      .half_want_i  (half_want),
      .group_i      (group),
      .sel_sh_nxt_o (sel_sh_nxt[c]),
      .out_o        (lane_out[c])
    );
  end

  scl_merge #(.CHANNELS(CHANNELS), .SHW(SHW)) u_merge (
    .clk     (clk),
    .en_i    (lane_ctl.offs),
    .sh_i    (sel_sh_nxt),
    .group_o (group)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) state_nxt = (in_ch.kind == KIND_SAMPLE) ? ST_CALC : ST_FINAL;
      end
      ST_CALC:  state_nxt = ST_OFFS;
      ST_OFFS:  state_nxt = ST_FINAL;
      ST_FINAL: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Countdown: a sample ticks it down, and at zero it disarms and fires the copy
  always_comb begin
    cd_on_nxt   = cd_on_r;
    cd_left_nxt = cd_left_r;
    fire_nxt    = fire_r;
    if (acc) begin
      fire_nxt = 1'b0;
      case (in_ch.kind)
        KIND_SAMPLE: begin
          if (cd_on_r) begin
            if (cd_left_r != '0) begin
              cd_left_nxt = cd_left_r - 1'b1;
            end else begin
              cd_on_nxt = 1'b0;
              fire_nxt  = 1'b1;
            end
          end
        end
        KIND_ARM: begin
          cd_on_nxt   = 1'b1;
          cd_left_nxt = in_ch.latch_delay;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cd_on_r     <= 1'b0;
      cd_left_r   <= '0;
      fire_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cd_on_r   <= cd_on_nxt;
      cd_left_r <= cd_left_nxt;
      fire_r    <= fire_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      armed_r    <= cd_on_nxt;
      ctl_item_r <= (in_ch.kind != KIND_SAMPLE);
    end
    if (emit) begin
      range_r <= armed_r;
      for (int c = 0; c < CHANNELS; c++) begin
        scaled_r[c] <= ctl_item_r ? '0 : lane_out[c];
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.scaled      = scaled_r;
  assign out_ch.range_armed = range_r;

endmodule

/* hdl/scl_cfg.sv */
module scl_cfg #(
  parameter int SAMPLE_BITS = scl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scl_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [scl_pkg::DATA_BITS-1:0]  pwdata,
  output logic [scl_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output scl_pkg::scl_mode_t             mode_o,
  output logic signed [SAMPLE_BITS-1:0]  mid_want_o,
  output logic signed [SAMPLE_BITS-1:0]  half_want_o
);
  import scl_pkg::*;

  logic signed [SAMPLE_BITS-1:0] tmin_r;
  logic signed [SAMPLE_BITS-1:0] tmax_r;
  logic                          tied_r;
  logic                          latched_r;
  logic [REG_IDX_BITS-1:0]       idx;
  logic                          wr;
  logic signed [SAMPLE_BITS-1:0] ta;
  logic signed [SAMPLE_BITS-1:0] tb_raw;
  logic signed [SAMPLE_BITS-1:0] tb;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_BITS-1:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmin_r    <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      tmax_r    <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      tied_r    <= 1'b0;
      latched_r <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_TMIN:    tmin_r    <= pwdata[SAMPLE_BITS-1:0];
        REG_TMAX:    tmax_r    <= pwdata[SAMPLE_BITS-1:0];
        REG_TIED:    tied_r    <= pwdata[0];
        REG_LATCHED: latched_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TMIN:    prdata = DATA_BITS'($unsigned(tmin_r));
      REG_TMAX:    prdata = DATA_BITS'($unsigned(tmax_r));
      REG_TIED:    prdata = DATA_BITS'(tied_r);
      REG_LATCHED: prdata = DATA_BITS'(latched_r);
      default:     prdata = '0;
    endcase
  end

  // Target halves; raise the upper half to the lower one when inverted
  assign ta          = tmin_r >>> 1;
  assign tb_raw      = tmax_r >>> 1;
  assign tb          = (tb_raw < ta) ? ta : tb_raw;
  assign mid_want_o  = ta + tb;
  assign half_want_o = tb - ta;

  assign mode_o.tied    = tied_r;
  assign mode_o.latched = latched_r;

endmodule

/* hdl/scl_lane.sv */
module scl_lane #(
  parameter int SAMPLE_BITS = scl_pkg::SAMPLE_BITS_DEF,
  parameter int SHW         = $clog2(SAMPLE_BITS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scl_pkg::scl_lane_ctl_t        ctl_i,
  input  scl_pkg::scl_mode_t            mode_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_i,
  input  logic signed [SAMPLE_BITS-1:0] mid_want_i,
  input  logic signed [SAMPLE_BITS-1:0] half_want_i,
  input  logic [SHW-1:0]                group_i,
  output logic [SHW-1:0]                sel_sh_nxt_o,
  output logic [SAMPLE_BITS-1:0]        out_o
);
  import scl_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] min_r;
  logic signed [SAMPLE_BITS-1:0] max_r;
  logic [SHW-1:0]                held_sh_r;
  logic signed [SAMPLE_BITS-1:0] held_off_r;
  logic signed [SAMPLE_BITS-1:0] smp_r;
  logic [SHW-1:0]                run_sh_r;
  logic signed [SAMPLE_BITS-1:0] mid_r;
  logic signed [SAMPLE_BITS-1:0] run_off_r;

  logic signed [SAMPLE_BITS-1:0] hi;
  logic signed [SAMPLE_BITS-1:0] a;
  logic signed [SAMPLE_BITS-1:0] b;
  logic signed [SAMPLE_BITS-1:0] mid_nxt;
  logic [SAMPLE_BITS-1:0]        half;
  logic [SAMPLE_BITS-1:0]        fits;
  logic [SHW-1:0]                run_sh_nxt;
  logic signed [SAMPLE_BITS-1:0] run_off_nxt;
  logic [SHW-1:0]                sel_sh;
  logic [SHW-1:0]                use_sh;
  logic signed [SAMPLE_BITS-1:0] sel_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r      <= SMP_MAX;
      max_r      <= SMP_MIN;
      held_sh_r  <= '0;
      held_off_r <= '0;
    end else begin
      if (ctl_i.trk_clr) begin
        min_r <= SMP_MAX;
        max_r <= SMP_MIN;
      end else if (ctl_i.track) begin
        if (smp_i < min_r) min_r <= smp_i;
        if (smp_i > max_r) max_r <= smp_i;
      end
      if (ctl_i.held_clr) begin
        held_sh_r  <= '0;
        held_off_r <= '0;
      end else if (ctl_i.offs && ctl_i.fire) begin
        held_sh_r  <= run_sh_r;
        held_off_r <= run_off_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.track) smp_r <= smp_i;
    if (ctl_i.calc) begin
      run_sh_r <= run_sh_nxt;
      mid_r    <= mid_nxt;
    end
    if (ctl_i.offs) run_off_r <= run_off_nxt;
  end

  // Span of the tracked range; an empty range collapses to zero span
  assign hi      = (max_r < min_r) ? min_r : max_r;
  assign a       = min_r >>> 1;
  assign b       = hi >>> 1;
  assign mid_nxt = a + b;
  assign half    = $unsigned(b - a);

  // Every candidate shift is tested at once; take the smallest that fits
  always_comb begin
    for (int s = 0; s < SAMPLE_BITS; s++) begin
      fits[s] = (half >> s) <= $unsigned(half_want_i);
    end
    run_sh_nxt = '0;
    for (int s = SAMPLE_BITS - 1; s >= 0; s--) begin
      if (fits[s]) run_sh_nxt = SHW'(s);
    end
  end

  assign run_off_nxt = mid_want_i - (mid_r >>> run_sh_r);

  assign sel_sh_nxt_o = (mode_i.latched && !ctl_i.fire) ? held_sh_r : run_sh_r;

  assign sel_sh  = mode_i.latched ? held_sh_r : run_sh_r;
  assign sel_off = mode_i.latched ? held_off_r : run_off_r;
  assign use_sh  = mode_i.tied ? group_i : sel_sh;
  assign out_o   = $unsigned((smp_r >>> use_sh) + sel_off);

endmodule

/* hdl/scl_merge.sv */
module scl_merge #(
  parameter int CHANNELS = scl_pkg::CHANNELS_DEF,
  parameter int SHW      = $clog2(scl_pkg::SAMPLE_BITS_DEF)
) (
  input  logic           clk,
  input  logic           en_i,
  input  logic [SHW-1:0] sh_i [CHANNELS],
  output logic [SHW-1:0] group_o
);
  import scl_pkg::*;

  logic [SHW-1:0] group_r;
  logic [SHW-1:0] group_nxt;

  always_comb begin
    group_nxt = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (sh_i[c] > group_nxt) group_nxt = sh_i[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) group_r <= group_nxt;
  end

  assign group_o = group_r;

endmodule

/* hdl/scl_chk.sv */
module scl_chk #(
  parameter int CHANNELS    = scl_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = scl_pkg::SAMPLE_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [1:0]                           in_kind,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [CHANNELS-1:0][SAMPLE_BITS-1:0] out_scaled,
  input logic                                 out_armed
);
  import scl_pkg::*;

  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) pend_nxt = pend_r + 1'b1;
    else if (!in_acc && out_acc) pend_nxt = pend_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else        pend_r <= pend_nxt;
  end

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scaled) && $stable(out_armed))
    else $error("stalled result beat changed");

  // A sample beat keeps the input closed through its calculate, offset and final steps
  a_sample_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_kind == KIND_SAMPLE) |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input reopened before sample finished");

  // No result without an accepted item behind it
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without accepted item");

  // At most one item in work plus one waiting result
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many items in flight");

endmodule

bind multichannel_autorange_scaler_unit scl_chk #(
  .CHANNELS    (CHANNELS),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_scl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_kind    (in_ch.kind),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_scaled (out_ch.scaled),
  .out_armed  (out_ch.range_armed)
);
